/* rtl/core/length_prefixed_frame_parser_core_defines.svh */
// assertion macros shared by the frame parser rtl
// every user must have clk and rst in scope at the point of use
`ifndef LENGTH_PREFIXED_FRAME_PARSER_CORE_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_PARSER_CORE_DEFINES_SVH

// condition must hold at every edge outside reset
`define LPFP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// same-cycle implication
`define LPFP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LPFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/lpfp_pkg.sv */
// types and constants of the length-prefixed frame parser
// no dependencies; imported by every other rtl file but the macro header
`default_nettype none

package lpfp_pkg;

  // parser phase
  typedef enum logic [1:0] {
    PH_WAIT    = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_END     = 2'd3
  } phase_t;

  // event reported with every byte
  typedef enum logic [2:0] {
    EV_START     = 3'd0,
    EV_LENGTH    = 3'd1,
    EV_PAYLOAD   = 3'd2,
    EV_COMPLETE  = 3'd3,
    EV_BAD_START = 3'd4,
    EV_BAD_END   = 3'd5,
    EV_ZERO_LEN  = 3'd6
  } event_t;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_CHAR = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_END_CHAR   = 2'd1;

  localparam logic [7:0] START_CHAR_RESET = 8'd58;
  localparam logic [7:0] END_CHAR_RESET   = 8'd10;

  typedef struct packed {
    logic [7:0] data_in;
  } byte_item_t;

  typedef struct packed {
    event_t     event_res;
    logic [7:0] data_out;
    logic [7:0] payload_index;
    logic [7:0] frame_length;
    logic       last_payload;
  } result_t;

endpackage

`default_nettype wire

/* rtl/core/lpfp_byte_if.sv */
// valid/ready channel carrying one raw stream byte per transaction
// depends on lpfp_pkg
`default_nettype none

interface lpfp_byte_if
  import lpfp_pkg::*;
();
  logic       valid;
  logic       ready;
  byte_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/core/lpfp_result_if.sv */
// valid/ready channel carrying one parser result per transaction
// depends on lpfp_pkg
`default_nettype none

interface lpfp_result_if
  import lpfp_pkg::*;
();
  logic    valid;
  logic    ready;
  result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/core/length_prefixed_frame_parser_core.sv */
// Length-prefixed frame parser. Each byte taken on stream gives exactly one
// result on report: event code, the byte, its payload index, the declared
// length and a last-payload flag. Frames are start_char, a nonzero length
// byte, that many payload bytes, end_char. One byte is accepted per clock
// cycle sustained while report takes results; once the result buffer is
// full and a byte is held, stream.ready drops. Each byte is held in the input
// register while the phase/counter update computes its result, which is
// written into a two-entry result buffer. Write start_char and end_char only
// while the block is idle. No clearing pass after reset.
`default_nettype none

module length_prefixed_frame_parser_core
  import lpfp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [7:0]             cfg_data,
  lpfp_byte_if.sink                   stream,
  lpfp_result_if.source               report
);

  logic [7:0] start_char_q;
  logic [7:0] end_char_q;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       buf_ready;
  logic       fire;
  result_t    step_res;

  assign fire         = in_valid && buf_ready;
  assign stream.ready = !in_valid || buf_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_char_q <= START_CHAR_RESET;
      end_char_q   <= END_CHAR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_CHAR: start_char_q <= cfg_data;
        CFG_END_CHAR:   end_char_q   <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (stream.ready) begin
      in_valid <= stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) in_byte <= stream.payload.data_in;
  end

  lpfp_step u_step (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .data_in    (in_byte),
    .start_char (start_char_q),
    .end_char   (end_char_q),
    .res        (step_res)
  );

  lpfp_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .push_data (step_res),
    .ready     (buf_ready),
    .report    (report)
  );

endmodule

`default_nettype wire

/* rtl/core/lpfp_step.sv */
// parse state and step logic: one byte in, one result out
// depends on lpfp_pkg and the assertion macro header
`default_nettype none
`include "length_prefixed_frame_parser_core_defines.svh"

module lpfp_step
  import lpfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       fire,
  input  wire logic [7:0] data_in,
  input  wire logic [7:0] start_char,
  input  wire logic [7:0] end_char,
  output result_t         res
);

  phase_t     phase, phase_next;
  logic [7:0] declared_length, declared_length_next;
  logic [7:0] write_index, write_index_next;
  logic [7:0] index_inc;

  assign index_inc = write_index + 8'd1;

  // state register, advanced once per consumed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_WAIT;
      declared_length <= 8'd0;
      write_index     <= 8'd0;
    end else if (fire) begin
      phase           <= phase_next;
      declared_length <= declared_length_next;
      write_index     <= write_index_next;
    end
  end

  // next state and result for the current byte
  always_comb begin
    phase_next           = phase;
    declared_length_next = declared_length;
    write_index_next     = write_index;
    res.event_res        = EV_BAD_START;
    res.data_out         = data_in;
    res.payload_index    = 8'd0;
    res.frame_length     = 8'd0;
    res.last_payload     = 1'b0;
    unique case (phase)
      PH_WAIT: begin
        declared_length_next = 8'd0;
        write_index_next     = 8'd0;
        if (data_in == start_char) begin
          res.event_res = EV_START;
          phase_next    = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        write_index_next = 8'd0;
        if (data_in == 8'd0) begin
          res.event_res        = EV_ZERO_LEN;
          declared_length_next = 8'd0;
          phase_next           = PH_WAIT;
        end else begin
          res.event_res        = EV_LENGTH;
          res.frame_length     = data_in;
          declared_length_next = data_in;
          phase_next           = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        res.event_res     = EV_PAYLOAD;
        res.payload_index = write_index;
        res.frame_length  = declared_length;
        write_index_next  = index_inc;
        if (index_inc == declared_length || declared_length == 8'd0) begin
          res.last_payload = 1'b1;
          phase_next       = PH_END;
        end
      end
      PH_END: begin
        res.frame_length     = declared_length;
        res.event_res        = (data_in == end_char) ? EV_COMPLETE : EV_BAD_END;
        phase_next           = PH_WAIT;
        declared_length_next = 8'd0;
        write_index_next     = 8'd0;
      end
    endcase
  end

  `LPFP_ASSERT_NEXT(a_last_goes_to_end, fire && res.last_payload, phase == PH_END, "last payload byte did not move to end phase")
  `LPFP_ASSERT_NEXT(a_zero_len_waits, fire && res.event_res == EV_ZERO_LEN, phase == PH_WAIT && declared_length == 8'd0, "zero length did not return to wait")
  `LPFP_ASSERT_NEXT(a_end_clears, fire && phase == PH_END, phase == PH_WAIT && write_index == 8'd0, "end phase did not clear frame state")

endmodule

`default_nettype wire

/* rtl/core/lpfp_skid.sv */
// two-entry result buffer between the step logic and the result channel
// depends on lpfp_pkg, lpfp_result_if and the assertion macro header
`default_nettype none
`include "length_prefixed_frame_parser_core_defines.svh"

module lpfp_skid
  import lpfp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire result_t  push_data,
  output logic          ready,
  lpfp_result_if.source report
);

  result_t    slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop          = report.valid && report.ready;
  assign ready        = (count != 2'd2);
  assign report.valid = (count != 2'd0);
  assign report.payload = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // result storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  `LPFP_ASSERT_ALWAYS(a_count_range, count != 2'd3, "result buffer count out of range")
  `LPFP_ASSERT_IMPL(a_no_push_full, push, count != 2'd2, "push into full result buffer")
  `LPFP_ASSERT_NEXT(a_pending_stays, report.valid && !report.ready, report.valid, "pending result dropped")

endmodule

`default_nettype wire

/* sim/testbench.sv */
// self-checking testbench for length_prefixed_frame_parser_core
// depends on lpfp_pkg, lpfp_byte_if, lpfp_result_if and the core rtl
// drives framed byte traffic under several start/end settings and checks every result
`timescale 1ns / 1ps

module testbench;
  import lpfp_pkg::*;

  // register indexes the core must ignore
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;
  localparam int DRAIN_CYCLES = 8;
  localparam int SETTLE_NS = 2_000_000;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [7:0] cfg_data;

  lpfp_byte_if   stream_ch ();
  lpfp_result_if report_ch ();

  length_prefixed_frame_parser_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stream    (stream_ch),
    .report    (report_ch)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // parser shadow state and register copies
  phase_t     prs_phase;
  logic [7:0] prs_length;
  logic [7:0] prs_index;
  logic [7:0] cur_start_char;
  logic [7:0] cur_end_char;

  logic [7:0] pending_bytes[$];
  result_t    expected_results[$];

  bit byte_taken;
  bit calm;
  int send_gap;
  int stall_left;
  int errors;
  int bytes_taken;
  int results_seen;
  int settings_run;
  int ev_count[7];

  // next result of the parser for one byte, advancing the shadow state
  function automatic result_t parse_byte(input logic [7:0] b);
    result_t r;
    logic [7:0] nxt;
    r = '0;
    r.data_out = b;
    r.event_res = EV_BAD_START;
    nxt = prs_index + 8'd1;
    case (prs_phase)
      PH_WAIT: begin
        prs_length = 8'd0;
        prs_index = 8'd0;
        if (b == cur_start_char) begin
          r.event_res = EV_START;
          prs_phase = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        prs_index = 8'd0;
        if (b == 8'd0) begin
          r.event_res = EV_ZERO_LEN;
          prs_length = 8'd0;
          prs_phase = PH_WAIT;
        end else begin
          r.event_res = EV_LENGTH;
          prs_length = b;
          r.frame_length = b;
          prs_phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        r.event_res = EV_PAYLOAD;
        r.payload_index = prs_index;
        r.frame_length = prs_length;
        if (nxt == prs_length || prs_length == 8'd0) begin
          r.last_payload = 1'b1;
          prs_phase = PH_END;
        end
        prs_index = nxt;
      end
      default: begin
        r.frame_length = prs_length;
        r.event_res = (b == cur_end_char) ? EV_COMPLETE : EV_BAD_END;
        prs_phase = PH_WAIT;
        prs_length = 8'd0;
        prs_index = 8'd0;
      end
    endcase
    return r;
  endfunction

  // register write, mirrored into the shadow copies
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_START_CHAR: cur_start_char = val;
      CFG_END_CHAR:   cur_end_char = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // block until every byte is sent and every result has come back
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_bytes.size() > 0 || stream_ch.valid || expected_results.size() > 0);
  endtask

  // payload bytes lean toward the framing characters now and then
  function automatic logic [7:0] payload_byte();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return cur_start_char;
    if (pick == 1) return cur_end_char;
    return 8'($urandom_range(0, 255));
  endfunction

  // one frame with a given length, closed correctly or not
  task automatic add_frame(input logic [7:0] len, input bit good_end);
    logic [7:0] tail;
    pending_bytes.push_back(cur_start_char);
    pending_bytes.push_back(len);
    for (int i = 0; i < len; i++) pending_bytes.push_back(payload_byte());
    if (good_end) begin
      tail = cur_end_char;
    end else begin
      tail = ($urandom_range(0, 2) == 0) ? cur_start_char : 8'($urandom_range(0, 255));
      if (tail == cur_end_char) tail = tail ^ 8'h01;
    end
    pending_bytes.push_back(tail);
  endtask

  // mostly well-formed frames, the rest broken frames and line noise
  task automatic queue_traffic(input int n);
    int goal;
    int kind;
    logic [7:0] len;
    goal = pending_bytes.size() + n;
    while (pending_bytes.size() < goal) begin
      kind = $urandom_range(0, 99);
      len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(17, 48))
                                        : 8'($urandom_range(1, 16));
      if (kind < 70) begin
        add_frame(len, 1'b1);
      end else if (kind < 80) begin
        add_frame(len, 1'b0);
      end else if (kind < 86) begin
        pending_bytes.push_back(cur_start_char);
        pending_bytes.push_back(8'd0);
      end else if (kind < 90) begin
        // frame cut short, the rest lands on whatever follows
        pending_bytes.push_back(cur_start_char);
        pending_bytes.push_back(len);
        repeat ($urandom_range(0, 3)) pending_bytes.push_back(payload_byte());
      end else begin
        repeat ($urandom_range(1, 4)) pending_bytes.push_back(payload_byte());
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // byte transaction accepted: predict its result
  always @(posedge clk) begin
    if (!rst && stream_ch.valid && stream_ch.ready) begin
      expected_results.push_back(parse_byte(stream_ch.payload.data_in));
      bytes_taken++;
      byte_taken = 1'b1;
    end
  end

  // byte driver with random send gaps
  always @(negedge clk) begin : byte_driver
    logic       nv;
    logic [7:0] nb;
    nv = stream_ch.valid;
    nb = stream_ch.payload.data_in;
    if (byte_taken) begin
      byte_taken = 1'b0;
      nv = 1'b0;
    end
    if (rst) begin
      nv = 1'b0;
    end else if (!nv) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_bytes.size() > 0) begin
        if (!calm && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(1, 18) - 1;
        end else begin
          nb = pending_bytes.pop_front();
          nv = 1'b1;
        end
      end
    end
    stream_ch.valid <= nv;
    stream_ch.payload.data_in <= nb;
  end

  // result backpressure in bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      report_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(1, 18) - 1;
      report_ch.ready <= 1'b0;
    end else begin
      report_ch.ready <= 1'b1;
    end
  end

  // result transaction: compare against the oldest prediction
  always @(posedge clk) begin : report_check
    result_t want;
    if (!rst && report_ch.valid && report_ch.ready) begin
      results_seen++;
      if (int'(report_ch.payload.event_res) < 7) ev_count[int'(report_ch.payload.event_res)]++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual event %0d byte %0d",
                 $time, report_ch.payload.event_res, report_ch.payload.data_out);
      end else begin
        want = expected_results.pop_front();
        check_field("event_res", want.event_res, report_ch.payload.event_res);
        check_field("data_out", want.data_out, report_ch.payload.data_out);
        check_field("payload_index", want.payload_index, report_ch.payload.payload_index);
        check_field("frame_length", want.frame_length, report_ch.payload.frame_length);
        check_field("last_payload", want.last_payload, report_ch.payload.last_payload);
      end
    end
  end

  // run-away guard
  initial begin
    #SETTLE_NS;
    $display("[FAIL] regression broken");
    $finish;
  end

  // sequence of register settings and traffic
  initial begin
    logic [7:0] directed[] = '{
      8'hFF, 8'h00,
      START_CHAR_RESET, 8'h00,
      START_CHAR_RESET, 8'h01, 8'h00, END_CHAR_RESET,
      START_CHAR_RESET, 8'h02, 8'hFF, END_CHAR_RESET, START_CHAR_RESET,
      8'h7F,
      START_CHAR_RESET, 8'h03, START_CHAR_RESET, END_CHAR_RESET, 8'h80, END_CHAR_RESET
    };
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = 8'd0;
    stream_ch.valid = 1'b0;
    stream_ch.payload = '0;
    report_ch.ready = 1'b0;
    prs_phase = PH_WAIT;
    prs_length = 8'd0;
    prs_index = 8'd0;
    cur_start_char = START_CHAR_RESET;
    cur_end_char = END_CHAR_RESET;
    calm = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset values: bad start, zero length, bad end on a start char, chars in payload
    foreach (directed[i]) pending_bytes.push_back(directed[i]);
    wait_idle();
    settings_run++;

    // spare indexes must leave both characters alone
    write_reg(CFG_SPARE_LO, 8'h00);
    write_reg(CFG_SPARE_HI, 8'hFF);
    queue_traffic(120);
    add_frame(8'd255, 1'b1);
    queue_traffic(130);
    wait_idle();
    settings_run++;

    // extremes of both registers
    write_reg(CFG_START_CHAR, 8'h00);
    write_reg(CFG_END_CHAR, 8'hFF);
    queue_traffic(300);
    wait_idle();
    settings_run++;

    write_reg(CFG_START_CHAR, 8'hFF);
    write_reg(CFG_END_CHAR, 8'h00);
    queue_traffic(300);
    wait_idle();
    settings_run++;

    // start and end share one value; full rate both sides
    write_reg(CFG_START_CHAR, 8'hA5);
    write_reg(CFG_END_CHAR, 8'hA5);
    calm = 1'b1;
    queue_traffic(250);
    wait_idle();
    settings_run++;

    calm = 1'b0;
    write_reg(CFG_START_CHAR, 8'($urandom_range(0, 255)));
    write_reg(CFG_END_CHAR, 8'($urandom_range(0, 255)));
    queue_traffic(250);
    wait_idle();
    settings_run++;

    // back to reset values, no idling to the end
    write_reg(CFG_START_CHAR, START_CHAR_RESET);
    write_reg(CFG_END_CHAR, END_CHAR_RESET);
    calm = 1'b1;
    queue_traffic(250);
    wait_idle();
    settings_run++;

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived, expected event %0d, actual none",
               $time, expected_results.size(), expected_results[0].event_res);
    end

    $display("covered %0d bytes and %0d results under %0d register settings",
             bytes_taken, results_seen, settings_run);
    $display("events: start %0d, length %0d, payload %0d, complete %0d, bad start %0d, %s",
             ev_count[EV_START], ev_count[EV_LENGTH], ev_count[EV_PAYLOAD],
             ev_count[EV_COMPLETE], ev_count[EV_BAD_START],
             $sformatf("bad end %0d, zero length %0d", ev_count[EV_BAD_END],
                       ev_count[EV_ZERO_LEN]));
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/lpfp_pkg.sv
rtl/core/lpfp_byte_if.sv
rtl/core/lpfp_result_if.sv
rtl/core/lpfp_step.sv
rtl/core/lpfp_skid.sv
rtl/core/length_prefixed_frame_parser_core.sv
sim/testbench.sv
